/* hdl/lrs_pkg.sv */
// Shared types and constants for the link receive supervisor.
package lrs_pkg;

  // Packet framing and failure policy
  localparam int unsigned WORDS_PER_PACKET = 16;
  localparam int unsigned FAIL_LIMIT       = 5;
  localparam int unsigned FAIL_MAX         = 7;

  // Register reset values
  localparam logic [7:0]  EXPECTED_TYPE_RST = 8'd0;
  localparam logic [15:0] SILENCE_WIN_RST   = 16'd100;
  localparam logic [15:0] LOST_TIMEOUT_RST  = 16'd500;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_EXPECTED_TYPE = 2'd0,
    CFG_SILENCE_WIN   = 2'd1,
    CFG_LOST_TIMEOUT  = 2'd2
  } cfg_index_t;

  // One input item
  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic [15:0] data_word;
    logic        last_word;
    logic [7:0]  pkt_type;
    logic [31:0] packet_check;
  } item_t;

  // One result item
  typedef struct packed {
    logic packet_accepted;
    logic packet_rejected;
    logic desync;
    logic link_lost;
    logic receiver_reset;
  } result_t;

  // Live register values
  typedef struct packed {
    logic [7:0]  expected_type;
    logic [15:0] silence_window_ms;
    logic [15:0] lost_timeout_ms;
  } cfg_t;

endpackage

/* hdl/lrs_cfg_regs.sv */
// Configuration register file for the link receive supervisor.
module lrs_cfg_regs import lrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        cfg_ready,
  output cfg_t        cfg
);

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Register write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_type     <= EXPECTED_TYPE_RST;
      cfg.silence_window_ms <= SILENCE_WIN_RST;
      cfg.lost_timeout_ms   <= LOST_TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_EXPECTED_TYPE: cfg.expected_type     <= cfg_data[7:0];
        CFG_SILENCE_WIN:   cfg.silence_window_ms <= cfg_data;
        CFG_LOST_TIMEOUT:  cfg.lost_timeout_ms   <= cfg_data;
        default: ;  // unused index, ignored
      endcase
    end
  end

endmodule

/* hdl/lrs_core.sv */
// Per-item packet check and link timing state for the link receive supervisor.
module lrs_core import lrs_pkg::*; #(
  parameter int unsigned PKT_WORDS      = WORDS_PER_PACKET,
  parameter int unsigned FAIL_THRESHOLD = FAIL_LIMIT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic [4:0]  word_index;
  logic [31:0] code_accumulator;
  logic [2:0]  fail_count;
  logic        desync_flag;
  logic        lost_flag;
  logic [31:0] last_packet_time;

  logic [4:0]  word_index_next;
  logic [31:0] code_accumulator_next;
  logic [2:0]  fail_count_next;
  logic        desync_flag_next;
  logic        lost_flag_next;
  logic [31:0] last_packet_time_next;

  logic [4:0]  base_index;
  logic [31:0] base_code;
  logic [4:0]  stored_index;
  logic [31:0] stored_code;
  logic [4:0]  bit_pos;
  logic        div3;
  logic        even;
  logic [31:0] elapsed;
  logic        done;
  logic        count_ok;
  logic        good;
  logic        silence_hit;
  logic [2:0]  fail_inc;

  // Divisible by 3: base-4 digits sum to a multiple of 3
  function automatic logic is_div3(input logic [15:0] w);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(w[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    return (t == 3'd0) || (t == 3'd3) || (t == 3'd6);
  endfunction

  assign div3     = is_div3(item.data_word);
  assign even     = ~item.data_word[0];
  assign done     = item.command & item.last_word;
  assign elapsed  = item.now_ms - last_packet_time;
  assign fail_inc = (fail_count < 3'(FAIL_MAX)) ? fail_count + 3'd1 : fail_count;

  // While desynchronized, silence window expiry discards the partial packet
  assign silence_hit = ~done & desync_flag & (elapsed > 32'(cfg.silence_window_ms));
  assign base_index  = silence_hit ? 5'd0 : word_index;
  assign base_code   = silence_hit ? 32'd0 : code_accumulator;

  // Store the word into the check code, saturating at a full packet
  assign bit_pos = {base_index[3:0], 1'b0};
  always_comb begin
    stored_index = base_index;
    stored_code  = base_code;
    if (base_index < 5'(PKT_WORDS)) begin
      stored_code  = base_code | (32'(div3) << bit_pos) | (32'(even) << (bit_pos + 5'd1));
      stored_index = base_index + 5'd1;
    end
  end

  assign count_ok = (word_index == 5'(PKT_WORDS - 1));
  assign good     = count_ok && (item.pkt_type == cfg.expected_type)
                    && (item.packet_check == stored_code);

  // Next state and result
  always_comb begin
    word_index_next       = word_index;
    code_accumulator_next = code_accumulator;
    fail_count_next       = fail_count;
    desync_flag_next      = desync_flag;
    lost_flag_next        = lost_flag;
    last_packet_time_next = last_packet_time;
    result                = '0;
    if (done) begin
      if (!desync_flag) begin
        if (good) begin
          result.packet_accepted = 1'b1;
          fail_count_next        = 3'd0;
          lost_flag_next         = 1'b0;
        end else begin
          result.packet_rejected = 1'b1;
          fail_count_next        = fail_inc;
          if (fail_inc >= 3'(FAIL_THRESHOLD)) begin
            desync_flag_next = 1'b1;
          end
        end
      end
      word_index_next       = 5'd0;
      code_accumulator_next = 32'd0;
      last_packet_time_next = item.now_ms;
    end else begin
      if (silence_hit) begin
        desync_flag_next      = 1'b0;
        result.receiver_reset = 1'b1;
      end
      if (elapsed > 32'(cfg.lost_timeout_ms)) begin
        lost_flag_next = 1'b1;
      end
      word_index_next       = item.command ? stored_index : base_index;
      code_accumulator_next = item.command ? stored_code : base_code;
    end
    result.desync    = desync_flag_next;
    result.link_lost = lost_flag_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      word_index       <= '0;
      code_accumulator <= '0;
      fail_count       <= '0;
      desync_flag      <= 1'b0;
      lost_flag        <= 1'b0;
      last_packet_time <= '0;
    end else if (fire) begin
      word_index       <= word_index_next;
      code_accumulator <= code_accumulator_next;
      fail_count       <= fail_count_next;
      desync_flag      <= desync_flag_next;
      lost_flag        <= lost_flag_next;
      last_packet_time <= last_packet_time_next;
    end
  end

endmodule

/* hdl/link_receive_supervisor_unit.sv */
// Top level of the link receive supervisor: input register, core and result register.
// Each transfer on the item channel is one data word or a time poll and yields exactly one
// result transfer. An accepted item sits in the input register while the core evaluates it, and
// the result register loads the core's result as the item leaves the input register. One item
// per cycle is sustained while results drain; a stalled result register holds the input
// register, and the input stalls once both are full. Configuration writes take effect on the
// next cycle and are expected only while no item is in flight.
module link_receive_supervisor_unit import lrs_pkg::*; #(
  parameter int unsigned PKT_WORDS      = WORDS_PER_PACKET,
  parameter int unsigned FAIL_THRESHOLD = FAIL_LIMIT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_q_valid;
  result_t core_result;
  logic    fire;

  lrs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  // Held item moves on when the result register is free or being drained
  assign fire       = item_q_valid & (~result_valid | result_ready);
  assign item_ready = ~item_q_valid | fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_ready) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_q <= item;
    end
  end

  lrs_core #(
    .PKT_WORDS      (PKT_WORDS),
    .FAIL_THRESHOLD (FAIL_THRESHOLD)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item_q),
    .cfg    (cfg),
    .result (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= core_result;
    end
  end

endmodule
